>>> src/vector_to_pitch_yaw_defines.svh
// assertion macros shared by the vector_to_pitch_yaw checker
// no dependencies; include guard keeps it single-pass
`ifndef VECTOR_TO_PITCH_YAW_DEFINES_SVH
`define VECTOR_TO_PITCH_YAW_DEFINES_SVH

// same-cycle implication, held off during reset
`define VPY_ASSERT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define VPY_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/vpy_pkg.sv
// shared widths, constants, pipeline word types and the arctangent table
// for the vector_to_pitch_yaw block; no dependencies
package vpy_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int TABLE_LEN     = 40;
  localparam int GUARD_BITS    = 24;
  localparam int ANG_FRAC      = 12;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * DIFF_W - 1;
  localparam int NSUM_W    = SQ_W + 1;
  localparam int ROOT_W    = (NSUM_W + 1) / 2 + 1;
  localparam int TRIAL_W   = ROOT_W + ROOT_W + 1;
  localparam int IDX_W     = $clog2(TABLE_LEN > ROOT_W ? TABLE_LEN : ROOT_W);
  localparam int PRE_W     = DIFF_W + 2;
  localparam int CV_W      = PRE_W + GUARD_BITS + 1;
  localparam int ANG_W     = 29;
  localparam int ANG_OUT_W = ANG_W - ANG_FRAC;
  localparam int PITCH_W   = 15;
  localparam int YAW_W     = 16;
  localparam int DIST_W    = 33;

  localparam int YAW_LIM   = 23040;
  localparam int PITCH_LIM = 11520;

  localparam logic signed [ANG_W-1:0] ANG_90   = ANG_W'(90 * 524288);
  localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'(1 << (ANG_FRAC - 1));

  // atan(2^-i) in degrees * 2^19
  localparam logic [24:0] ATAN_TAB [TABLE_LEN] = '{
    25'd23592960, 25'd13927738, 25'd7359034, 25'd3735561, 25'd1875029,
    25'd938429, 25'd469329, 25'd234679, 25'd117341, 25'd58671,
    25'd29335, 25'd14668, 25'd7334, 25'd3667, 25'd1833,
    25'd917, 25'd458, 25'd229, 25'd115, 25'd57,
    25'd29, 25'd14, 25'd7, 25'd4, 25'd2,
    25'd1, 25'd0, 25'd0, 25'd0, 25'd0,
    25'd0, 25'd0, 25'd0, 25'd0, 25'd0,
    25'd0, 25'd0, 25'd0, 25'd0, 25'd0
  };

  typedef struct packed {
    logic valid;
    logic degen;
    logic yaw_zero;
  } tag_t;

  typedef struct packed {
    logic [NSUM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } root_lane_t;

  typedef struct packed {
    tag_t                      tag;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [DIFF_W-1:0]  dz;
    root_lane_t                h;
    root_lane_t                d;
  } root_word_t;

  typedef struct packed {
    logic signed [CV_W-1:0]  x;
    logic signed [CV_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  typedef struct packed {
    tag_t              tag;
    logic [DIST_W-1:0] distance;
    vec_t              yv;
    vec_t              pv;
  } cordic_word_t;

  function automatic logic signed [ANG_W-1:0] atan_of(logic [IDX_W-1:0] k);
    logic signed [ANG_W-1:0] a;
    a = '0;
    if (k < IDX_W'(TABLE_LEN)) begin
      a = ANG_W'(ATAN_TAB[k]);
    end
    return a;
  endfunction

endpackage

>>> src/vpy_if.sv
// valid/ready channel interfaces for point pairs in and angles out
// depends on vpy_pkg
interface vpy_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vpy_pkg::COORD_W-1:0]  src_x;
  logic signed [vpy_pkg::COORD_W-1:0]  src_y;
  logic signed [vpy_pkg::COORD_W-1:0]  src_z;
  logic signed [vpy_pkg::COORD_W-1:0]  dst_x;
  logic signed [vpy_pkg::COORD_W-1:0]  dst_y;
  logic signed [vpy_pkg::COORD_W-1:0]  dst_z;

  modport source (output valid, output src_x, output src_y, output src_z,
                  output dst_x, output dst_y, output dst_z, input ready);
  modport sink   (input valid, input src_x, input src_y, input src_z,
                  input dst_x, input dst_y, input dst_z, output ready);
endinterface

interface vpy_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [vpy_pkg::PITCH_W-1:0]  pitch;
  logic signed [vpy_pkg::YAW_W-1:0]    yaw;
  logic [vpy_pkg::DIST_W-1:0]          distance;
  logic                                degenerate;

  modport source (output valid, output pitch, output yaw, output distance,
                  output degenerate, input ready);
  modport sink   (input valid, input pitch, input yaw, input distance,
                  input degenerate, output ready);
endinterface

>>> src/vector_to_pitch_yaw.sv
// top level: difference, squares, root cell chain, cordic cell chain, output skid
// depends on vpy_pkg, vpy_if, vpy_root_cell, vpy_cordic_cell
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+----------------------------------------
//   in_chan   | in  | valid / ready | src_x/y/z, dst_x/y/z (signed Q16.16)
//   out_chan  | out | valid / ready | pitch, yaw (1/128 deg), distance, degenerate
//
// one transaction per cycle sustained while the skid entry is empty; each input
// transaction passes through the 34 root cells and the cordic cell chain on its
// way to the output
// reset clears the valid bit of every stage, the output register and the skid entry
// the whole pipe advances unless the skid entry is full; in_chan.ready is that flag,
// so a result waiting at the output still lets one more transaction move in
module vector_to_pitch_yaw (
  input  logic      clk,
  input  logic      rst_n,
  vpy_in_if.sink    in_chan,
  vpy_out_if.source out_chan
);

  localparam int DW = vpy_pkg::DIFF_W;

  typedef struct packed {
    logic                     valid;
    logic signed [DW-1:0]     dx;
    logic signed [DW-1:0]     dy;
    logic signed [DW-1:0]     dz;
  } diff_t;

  typedef struct packed {
    vpy_pkg::tag_t                  tag;
    logic signed [DW-1:0]           dx;
    logic signed [DW-1:0]           dy;
    logic signed [DW-1:0]           dz;
    logic [vpy_pkg::SQ_W-1:0]       sx;
    logic [vpy_pkg::SQ_W-1:0]       sy;
    logic [vpy_pkg::SQ_W-1:0]       sz;
  } sq_t;

  typedef struct packed {
    vpy_pkg::tag_t                  tag;
    logic signed [DW-1:0]           dx;
    logic signed [DW-1:0]           dy;
    logic signed [DW-1:0]           dz;
    logic [vpy_pkg::ROOT_W-1:0]     h;
    logic [vpy_pkg::ROOT_W-1:0]     distance;
  } rnd_t;

  typedef struct packed {
    logic signed [vpy_pkg::PITCH_W-1:0] pitch;
    logic signed [vpy_pkg::YAW_W-1:0]   yaw;
    logic [vpy_pkg::DIST_W-1:0]         distance;
    logic                               degenerate;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } tail_t;

  function automatic logic [DW-1:0] abs_diff(logic signed [DW-1:0] d);
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  // quadrant fold for x < 0, then scale by the guard bits
  function automatic vpy_pkg::vec_t cordic_pre(logic signed [vpy_pkg::PRE_W-1:0] x,
                                               logic signed [vpy_pkg::PRE_W-1:0] y);
    logic signed [vpy_pkg::PRE_W-1:0] xr;
    logic signed [vpy_pkg::PRE_W-1:0] yr;
    vpy_pkg::vec_t                    v;
    xr  = x;
    yr  = y;
    v.z = '0;
    if (x[vpy_pkg::PRE_W-1]) begin
      if (!y[vpy_pkg::PRE_W-1]) begin
        xr  = y;
        yr  = -x;
        v.z = vpy_pkg::ANG_90;
      end else begin
        xr  = -y;
        yr  = x;
        v.z = -vpy_pkg::ANG_90;
      end
    end
    v.x = vpy_pkg::CV_W'(xr) <<< vpy_pkg::GUARD_BITS;
    v.y = vpy_pkg::CV_W'(yr) <<< vpy_pkg::GUARD_BITS;
    return v;
  endfunction

  function automatic logic signed [vpy_pkg::ANG_OUT_W-1:0] ang_round(
      logic signed [vpy_pkg::ANG_W-1:0] z);
    logic signed [vpy_pkg::ANG_W-1:0] s;
    s = z + vpy_pkg::ANG_HALF;
    return vpy_pkg::ANG_OUT_W'(s >>> vpy_pkg::ANG_FRAC);
  endfunction

  logic   pipe_en;
  logic   in_take;

  diff_t  diff_nxt, diff_r;
  sq_t    sq_nxt, sq_r;
  vpy_pkg::root_word_t   root_in_nxt, root_in_r;
  vpy_pkg::root_word_t   root_w [vpy_pkg::ROOT_W+1];
  rnd_t   rnd_nxt, rnd_r;
  vpy_pkg::cordic_word_t cor_in_nxt, cor_in_r;
  vpy_pkg::cordic_word_t cor_w [vpy_pkg::CORDIC_STAGES+1];
  tail_t  tail_nxt, tail_r;

  logic   out_vld_nxt, out_vld_r;
  logic   skid_vld_nxt, skid_vld_r;
  res_t   out_data_r, skid_data_r;
  logic   load_out_tail, load_out_skid, load_skid;

  assign pipe_en       = !skid_vld_r;
  assign in_take       = in_chan.valid && pipe_en;
  assign in_chan.ready = pipe_en;

  // difference vector, 33 bits per axis
  always_comb begin
    diff_nxt.valid = in_take;
    diff_nxt.dx    = DW'(in_chan.dst_x) - DW'(in_chan.src_x);
    diff_nxt.dy    = DW'(in_chan.dst_y) - DW'(in_chan.src_y);
    diff_nxt.dz    = DW'(in_chan.dst_z) - DW'(in_chan.src_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_r.valid <= 1'b0;
    end else if (pipe_en) begin
      diff_r <= diff_nxt;
    end
  end

  // exact squares
  always_comb begin
    logic [DW-1:0] ax, ay, az;
    ax                  = abs_diff(diff_r.dx);
    ay                  = abs_diff(diff_r.dy);
    az                  = abs_diff(diff_r.dz);
    sq_nxt.tag.valid    = diff_r.valid;
    sq_nxt.tag.yaw_zero = (diff_r.dx == '0) && (diff_r.dy == '0);
    sq_nxt.tag.degen    = sq_nxt.tag.yaw_zero && (diff_r.dz == '0);
    sq_nxt.dx           = diff_r.dx;
    sq_nxt.dy           = diff_r.dy;
    sq_nxt.dz           = diff_r.dz;
    sq_nxt.sx           = ax * ax;
    sq_nxt.sy           = ay * ay;
    sq_nxt.sz           = az * az;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r.tag.valid <= 1'b0;
    end else if (pipe_en) begin
      sq_r <= sq_nxt;
    end
  end

  // sums of squares seed the root chain
  always_comb begin
    root_in_nxt.tag    = sq_r.tag;
    root_in_nxt.dx     = sq_r.dx;
    root_in_nxt.dy     = sq_r.dy;
    root_in_nxt.dz     = sq_r.dz;
    root_in_nxt.h.rem  = vpy_pkg::NSUM_W'(sq_r.sx) + vpy_pkg::NSUM_W'(sq_r.sy);
    root_in_nxt.h.root = '0;
    root_in_nxt.d.rem  = vpy_pkg::NSUM_W'(sq_r.sx) + vpy_pkg::NSUM_W'(sq_r.sy)
                       + vpy_pkg::NSUM_W'(sq_r.sz);
    root_in_nxt.d.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_in_r.tag.valid <= 1'b0;
    end else if (pipe_en) begin
      root_in_r <= root_in_nxt;
    end
  end

  assign root_w[0] = root_in_r;

  // msb first: cell j decides root bit ROOT_W-1-j
  for (genvar j = 0; j < vpy_pkg::ROOT_W; j++) begin : g_root
    vpy_root_cell u_root_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (pipe_en),
      .bit_idx (vpy_pkg::IDX_W'(vpy_pkg::ROOT_W - 1 - j)),
      .cin     (root_w[j]),
      .cout    (root_w[j+1])
    );
  end

  // round to nearest: floor root plus one when the remainder exceeds it
  always_comb begin
    vpy_pkg::root_word_t rw;
    rw               = root_w[vpy_pkg::ROOT_W];
    rnd_nxt.tag      = rw.tag;
    rnd_nxt.dx       = rw.dx;
    rnd_nxt.dy       = rw.dy;
    rnd_nxt.dz       = rw.dz;
    rnd_nxt.h        = rw.h.root
                     + vpy_pkg::ROOT_W'(rw.h.rem > vpy_pkg::NSUM_W'(rw.h.root));
    rnd_nxt.distance = rw.d.root
                     + vpy_pkg::ROOT_W'(rw.d.rem > vpy_pkg::NSUM_W'(rw.d.root));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r.tag.valid <= 1'b0;
    end else if (pipe_en) begin
      rnd_r <= rnd_nxt;
    end
  end

  // yaw vector (dx, dy), pitch vector (h, dz)
  always_comb begin
    cor_in_nxt.tag      = rnd_r.tag;
    cor_in_nxt.distance = vpy_pkg::DIST_W'(rnd_r.distance);
    cor_in_nxt.yv       = cordic_pre(vpy_pkg::PRE_W'(rnd_r.dx), vpy_pkg::PRE_W'(rnd_r.dy));
    cor_in_nxt.pv       = cordic_pre($signed(vpy_pkg::PRE_W'(rnd_r.h)),
                                     vpy_pkg::PRE_W'(rnd_r.dz));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cor_in_r.tag.valid <= 1'b0;
    end else if (pipe_en) begin
      cor_in_r <= cor_in_nxt;
    end
  end

  assign cor_w[0] = cor_in_r;

  for (genvar k = 0; k < vpy_pkg::CORDIC_STAGES; k++) begin : g_cordic
    vpy_cordic_cell u_cordic_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .stage_idx (vpy_pkg::IDX_W'(k)),
      .cin       (cor_w[k]),
      .cout      (cor_w[k+1])
    );
  end

  // angle rounding, saturation and the special cases
  always_comb begin
    vpy_pkg::cordic_word_t             cw;
    logic signed [vpy_pkg::ANG_OUT_W-1:0] ya;
    logic signed [vpy_pkg::ANG_OUT_W-1:0] pa;
    logic signed [vpy_pkg::ANG_OUT_W:0]   pn;
    cw = cor_w[vpy_pkg::CORDIC_STAGES];
    ya = ang_round(cw.yv.z);
    pa = ang_round(cw.pv.z);
    pn = -(($bits(pn))'(pa));
    if (ya > vpy_pkg::YAW_LIM) begin
      ya = vpy_pkg::ANG_OUT_W'(vpy_pkg::YAW_LIM);
    end else if (ya < -vpy_pkg::YAW_LIM) begin
      ya = vpy_pkg::ANG_OUT_W'(-vpy_pkg::YAW_LIM);
    end
    if (pn > vpy_pkg::PITCH_LIM) begin
      pn = ($bits(pn))'(vpy_pkg::PITCH_LIM);
    end else if (pn < -vpy_pkg::PITCH_LIM) begin
      pn = ($bits(pn))'(-vpy_pkg::PITCH_LIM);
    end
    tail_nxt.valid          = cw.tag.valid;
    tail_nxt.res.pitch      = vpy_pkg::PITCH_W'(pn);
    tail_nxt.res.yaw        = cw.tag.yaw_zero ? '0 : vpy_pkg::YAW_W'(ya);
    tail_nxt.res.distance   = cw.distance;
    tail_nxt.res.degenerate = cw.tag.degen;
    if (cw.tag.degen) begin
      tail_nxt.res.pitch    = '0;
      tail_nxt.res.yaw      = '0;
      tail_nxt.res.distance = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r.valid <= 1'b0;
    end else if (pipe_en) begin
      tail_r <= tail_nxt;
    end
  end

  // output register with one skid entry behind it
  always_comb begin
    logic take;
    take          = out_vld_r && out_chan.ready;
    out_vld_nxt   = out_vld_r;
    skid_vld_nxt  = skid_vld_r;
    load_out_tail = 1'b0;
    load_out_skid = 1'b0;
    load_skid     = 1'b0;
    if (skid_vld_r) begin
      if (take) begin
        load_out_skid = 1'b1;
        skid_vld_nxt  = 1'b0;
      end
    end else if (tail_r.valid) begin
      if (!out_vld_r || take) begin
        load_out_tail = 1'b1;
        out_vld_nxt   = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_vld_nxt = 1'b1;
      end
    end else if (take) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_tail) begin
      out_data_r <= tail_r.res;
    end else if (load_out_skid) begin
      out_data_r <= skid_data_r;
    end
    if (load_skid) begin
      skid_data_r <= tail_r.res;
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.pitch      = out_data_r.pitch;
  assign out_chan.yaw        = out_data_r.yaw;
  assign out_chan.distance   = out_data_r.distance;
  assign out_chan.degenerate = out_data_r.degenerate;

endmodule

>>> src/vpy_root_cell.sv
// one bit of the two pipelined square roots (horizontal length and distance)
// depends on vpy_pkg
module vpy_root_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [vpy_pkg::IDX_W-1:0]   bit_idx,
  input  vpy_pkg::root_word_t         cin,
  output vpy_pkg::root_word_t         cout
);

  // try setting root bit b: (r + 2^b)^2 <= n  <=>  rem >= r*2^(b+1) + 2^(2b)
  function automatic vpy_pkg::root_lane_t root_step(vpy_pkg::root_lane_t l,
                                                    logic [vpy_pkg::IDX_W-1:0] b);
    logic [vpy_pkg::TRIAL_W-1:0] trial;
    vpy_pkg::root_lane_t         o;
    trial = (vpy_pkg::TRIAL_W'(l.root) << (b + vpy_pkg::IDX_W'(1)))
          + (vpy_pkg::TRIAL_W'(1) << {b, 1'b0});
    o = l;
    if (vpy_pkg::TRIAL_W'(l.rem) >= trial) begin
      o.rem  = l.rem - vpy_pkg::NSUM_W'(trial);
      o.root = l.root | (vpy_pkg::ROOT_W'(1) << b);
    end
    return o;
  endfunction

  vpy_pkg::root_word_t word_nxt;
  vpy_pkg::root_word_t word_r;

  always_comb begin
    word_nxt   = cin;
    word_nxt.h = root_step(cin.h, bit_idx);
    word_nxt.d = root_step(cin.d, bit_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.tag.valid <= 1'b0;
    end else if (en) begin
      word_r <= word_nxt;
    end
  end

  assign cout = word_r;

endmodule

>>> src/vpy_cordic_cell.sv
// one vectoring rotation for both the yaw and the pitch vectors
// depends on vpy_pkg (arctangent table)
module vpy_cordic_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [vpy_pkg::IDX_W-1:0]   stage_idx,
  input  vpy_pkg::cordic_word_t       cin,
  output vpy_pkg::cordic_word_t       cout
);

  function automatic vpy_pkg::vec_t cordic_step(vpy_pkg::vec_t v,
                                                logic [vpy_pkg::IDX_W-1:0] k);
    logic signed [vpy_pkg::CV_W-1:0]  xs;
    logic signed [vpy_pkg::CV_W-1:0]  ys;
    logic signed [vpy_pkg::ANG_W-1:0] a;
    vpy_pkg::vec_t                    o;
    xs = v.x >>> k;
    ys = v.y >>> k;
    a  = vpy_pkg::atan_of(k);
    // rotate toward the x axis: clockwise when y is non-negative
    if (!v.y[vpy_pkg::CV_W-1]) begin
      o.x = v.x + ys;
      o.y = v.y - xs;
      o.z = v.z + a;
    end else begin
      o.x = v.x - ys;
      o.y = v.y + xs;
      o.z = v.z - a;
    end
    return o;
  endfunction

  vpy_pkg::cordic_word_t word_nxt;
  vpy_pkg::cordic_word_t word_r;

  always_comb begin
    word_nxt    = cin;
    word_nxt.yv = cordic_step(cin.yv, stage_idx);
    word_nxt.pv = cordic_step(cin.pv, stage_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.tag.valid <= 1'b0;
    end else if (en) begin
      word_r <= word_nxt;
    end
  end

  assign cout = word_r;

endmodule

>>> src/vpy_checker.sv
// port-level checks on the result channel of vector_to_pitch_yaw, bound to the top
// depends on vpy_pkg and vector_to_pitch_yaw_defines.svh
`include "vector_to_pitch_yaw_defines.svh"

module vpy_props (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [vpy_pkg::PITCH_W-1:0] out_pitch,
  input logic signed [vpy_pkg::YAW_W-1:0]   out_yaw,
  input logic [vpy_pkg::DIST_W-1:0]         out_distance,
  input logic                               out_degenerate
);

  localparam int BUNDLE_W = vpy_pkg::PITCH_W + vpy_pkg::YAW_W + vpy_pkg::DIST_W + 1;

  logic                fields_zero;
  logic                angles_ok;
  logic [BUNDLE_W-1:0] out_bundle;

  assign fields_zero = (out_pitch == 0) && (out_yaw == 0) && (out_distance == 0);
  assign angles_ok   = (out_pitch <= vpy_pkg::PITCH_LIM) && (out_pitch >= -vpy_pkg::PITCH_LIM)
                    && (out_yaw <= vpy_pkg::YAW_LIM) && (out_yaw >= -vpy_pkg::YAW_LIM);
  assign out_bundle  = {out_pitch, out_yaw, out_distance, out_degenerate};

  // coincident points give an all-zero result
  `VPY_ASSERT(a_degen_zero, clk, rst_n, out_valid && out_degenerate, fields_zero, "degenerate transaction with nonzero fields")

  // any nonzero difference rounds to a length of at least one lsb
  `VPY_ASSERT(a_dist_nonzero, clk, rst_n, out_valid && !out_degenerate, out_distance != 0, "zero distance on a non-degenerate transaction")

  `VPY_ASSERT(a_angle_range, clk, rst_n, out_valid, angles_ok, "angle outside saturation range")

  `VPY_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

  `VPY_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_bundle), "result changed while stalled")

endmodule

bind vector_to_pitch_yaw vpy_props u_vpy_props (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_pitch      (out_chan.pitch),
  .out_yaw        (out_chan.yaw),
  .out_distance   (out_chan.distance),
  .out_degenerate (out_chan.degenerate)
);
